>>> design/saa_pkg.sv
package saa_pkg;

	localparam int HEADER_BYTES  = 16;
	localparam int DEFAULT_ALIGN = 16;
	localparam int ARENA_BITS    = 16;
	localparam int MAX_RECORDS   = 64;
	localparam int ALIGN_LIMIT   = 4096;

	localparam int REC_AW   = $clog2(MAX_RECORDS);
	localparam int CNT_W    = REC_AW + 1;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 3;
	localparam int SIZE_W   = 17;
	localparam int ALIGN_W  = 13;
	localparam int OFF_W    = 16;
	localparam int PAD_W    = 12;
	localparam int TOP_W    = 17;
	localparam int BASE_W   = 32;
	localparam int CAP_W    = 17;
	localparam int CFG_AW   = 1;
	localparam int DIV_W    = BASE_W + 2;
	localparam int DCNT_W   = $clog2(DIV_W);
	localparam int SUM_W    = TOP_W + 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;
	localparam logic [STAT_W-1:0] ST_NULL    = 3'd5;

	localparam logic [CFG_AW-1:0] REG_BASE = 1'd0;
	localparam logic [CFG_AW-1:0] REG_CAP  = 1'd1;

	localparam logic [SUM_W-1:0] ARENA_LIMIT = SUM_W'(1 << ARENA_BITS);

	typedef logic [OFF_W+PAD_W-1:0] rec_t;

endpackage

>>> design/stack_arena_allocator_core.sv
// LIFO byte arena allocator with a bump pointer and a record table.
// Input channel (in_valid/in_ready): one beat carries command, request_size,
// alignment and data_offset. Allocate, free and reset are served one at a time.
// Output channel (out_valid/out_ready): one beat per input beat with status,
// result_offset, padding_used and used_bytes (arena top after the command).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 writes
// base_address, index 1 writes capacity; write only while the block is idle.
// Path from input beat to result beat:
//   reset, null free, zero-size allocate, undefined command: direct to output
//   allocate: bit-serial remainder over the 34-bit data address (one quotient
//     bit per cycle), then padding, fit check and output
//   free: a search up from record 0 to a match or the last record, one record
//     table read per cycle from the synchronous RAM
// A new beat is taken once the previous result is loaded in the output
// register. A stalled receiver holds the result; the block then stops
// after finishing at most one further command.
// After reset the arena is empty, base_address is 0, capacity is 65536.
module stack_arena_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [saa_pkg::CMD_W-1:0]     command,
	input  logic [saa_pkg::SIZE_W-1:0]    request_size,
	input  logic [saa_pkg::ALIGN_W-1:0]   alignment,
	input  logic [saa_pkg::OFF_W-1:0]     data_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [saa_pkg::STAT_W-1:0]    status,
	output logic [saa_pkg::OFF_W-1:0]     result_offset,
	output logic [saa_pkg::PAD_W-1:0]     padding_used,
	output logic [saa_pkg::TOP_W-1:0]     used_bytes,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [saa_pkg::CFG_AW-1:0]    cfg_index,
	input  logic [saa_pkg::BASE_W-1:0]    cfg_data
);
	import saa_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_PAD  = 3'd2;
	localparam logic [2:0] S_FIT  = 3'd3;
	localparam logic [2:0] S_SRCH = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]         state_q;
	logic [BASE_W-1:0]  base_q;
	logic [CAP_W-1:0]   cap_q;
	logic [TOP_W-1:0]   top_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [DIV_W-1:0]   dvd_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [ALIGN_W-1:0] div_a_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [PAD_W-1:0]   pad_q;
	logic [SIZE_W-1:0]  size_q;
	logic [OFF_W-1:0]   ptr_q;
	logic [REC_AW-1:0]  cmp_idx_q;

	logic [STAT_W-1:0]  pend_stat_q;
	logic [OFF_W-1:0]   pend_res_q;
	logic [PAD_W-1:0]   pend_pad_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [OFF_W-1:0]   res_q;
	logic [PAD_W-1:0]   pad_out_q;
	logic [TOP_W-1:0]   used_q;

	rec_t               mem [MAX_RECORDS];
	rec_t               rd_q;
	logic [REC_AW-1:0]  rd_addr;
	logic               mem_we;
	rec_t               wr_data;

	logic               in_fire;
	logic               out_free;
	logic [ALIGN_W-1:0] a_eff;
	logic [ALIGN_W:0]   r_shift;
	logic [ALIGN_W:0]   r_next;
	logic [SUM_W-1:0]   limit;
	logic [SUM_W-1:0]   data_sum;
	logic [SUM_W-1:0]   total_sum;
	logic               hit;
	logic               last_rec;
	logic [TOP_W-1:0]   free_top;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (alignment == '0) begin
			a_eff = ALIGN_W'(DEFAULT_ALIGN);
		end else if (alignment > ALIGN_W'(ALIGN_LIMIT)) begin
			a_eff = ALIGN_W'(ALIGN_LIMIT);
		end else begin
			a_eff = alignment;
		end
	end

	assign r_shift = {rem_q, dvd_q[DIV_W-1]};
	assign r_next  = (r_shift >= {1'b0, div_a_q}) ? r_shift - {1'b0, div_a_q} : r_shift;

	assign limit     = ({2'b0, cap_q} > ARENA_LIMIT) ? ARENA_LIMIT : SUM_W'(cap_q);
	assign data_sum  = SUM_W'(top_q) + SUM_W'(pad_q) + SUM_W'(HEADER_BYTES);
	assign total_sum = data_sum + SUM_W'(size_q);

	assign hit      = (rd_q[OFF_W+PAD_W-1:PAD_W] == ptr_q);
	assign last_rec = (CNT_W'(cmp_idx_q) + CNT_W'(1)) == cnt_q;
	assign free_top = TOP_W'(ptr_q) - TOP_W'(rd_q[PAD_W-1:0]) - TOP_W'(HEADER_BYTES);

	assign rd_addr = (state_q == S_SRCH) ? cmp_idx_q + REC_AW'(1) : '0;
	assign mem_we  = (state_q == S_FIT) && (total_sum <= limit)
		&& (cnt_q < CNT_W'(MAX_RECORDS));
	assign wr_data = {data_sum[OFF_W-1:0], pad_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[REC_AW-1:0]] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			cap_q  <= CAP_W'(1 << ARENA_BITS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE: base_q <= cfg_data;
				REG_CAP:  cap_q  <= cfg_data[CAP_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dvd_q     <= DIV_W'(base_q) + DIV_W'(top_q) + DIV_W'(HEADER_BYTES);
				dcnt_q    <= DCNT_W'(DIV_W - 1);
				div_a_q   <= a_eff;
				rem_q     <= '0;
				size_q    <= request_size;
				ptr_q     <= data_offset;
				cmp_idx_q <= '0;
			end
			S_DIV: begin
				dvd_q  <= dvd_q << 1;
				rem_q  <= r_next[ALIGN_W-1:0];
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			S_PAD: begin
				pad_q <= (rem_q == '0) ? '0 : PAD_W'(div_a_q - rem_q);
			end
			S_SRCH: begin
				cmp_idx_q <= cmp_idx_q + REC_AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			cnt_q       <= '0;
			pend_stat_q <= ST_OK;
			pend_res_q  <= '0;
			pend_pad_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pend_stat_q <= ST_OK;
						pend_res_q  <= '0;
						pend_pad_q  <= '0;
						state_q     <= S_OUT;
						case (command)
							CMD_ALLOC: begin
								if (request_size == '0) begin
									pend_stat_q <= ST_ZERO;
								end else begin
									state_q <= S_DIV;
								end
							end
							CMD_FREE: begin
								if (data_offset == '0) begin
									pend_stat_q <= ST_NULL;
								end else if (cnt_q == '0) begin
									pend_stat_q <= ST_UNKNOWN;
								end else begin
									state_q <= S_SRCH;
								end
							end
							CMD_RESET: begin
								top_q <= '0;
								cnt_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					state_q <= S_FIT;
				end
				S_FIT: begin
					if (total_sum > limit) begin
						pend_stat_q <= ST_NOSPACE;
					end else if (cnt_q >= CNT_W'(MAX_RECORDS)) begin
						pend_stat_q <= ST_FULL;
					end else begin
						pend_res_q <= data_sum[OFF_W-1:0];
						pend_pad_q <= pad_q;
						top_q      <= total_sum[TOP_W-1:0];
						cnt_q      <= cnt_q + CNT_W'(1);
					end
					state_q <= S_OUT;
				end
				S_SRCH: begin
					if (hit) begin
						top_q   <= free_top;
						cnt_q   <= CNT_W'(cmp_idx_q);
						state_q <= S_OUT;
					end else if (last_rec) begin
						pend_stat_q <= ST_UNKNOWN;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			status_q  <= pend_stat_q;
			res_q     <= pend_res_q;
			pad_out_q <= pend_pad_q;
			used_q    <= top_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_offset = res_q;
	assign padding_used  = pad_out_q;
	assign used_bytes    = used_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECORDS))
		else $error("record count above table size");

	a_srch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH |-> CNT_W'(cmp_idx_q) < cnt_q)
		else $error("search index past record count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAD |-> rem_q < div_a_q)
		else $error("remainder not below alignment");

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("record write without count increment");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(top_q) <= ARENA_LIMIT)
		else $error("top beyond arena");
`endif

endmodule

>>> tb/sv/stack_arena_allocator_core_tb.sv
module stack_arena_allocator_core_tb;

	import saa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [STAT_W-1:0] code;
		logic [OFF_W-1:0]  offset;
		logic [PAD_W-1:0]  pad;
		logic [TOP_W-1:0]  used;
	} reply_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		logic [OFF_W-1:0]   ptr;
		bit                 typed;
		reply_t             want;
	} step_row_t;

	localparam reply_t NONE = '0;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = CMD_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic [ALIGN_W-1:0] alignment = '0;
	logic [OFF_W-1:0] data_offset = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [OFF_W-1:0] result_offset;
	logic [PAD_W-1:0] padding_used;
	logic [TOP_W-1:0] used_bytes;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_AW-1:0] cfg_index = REG_BASE;
	logic [BASE_W-1:0] cfg_data = '0;

	// arena state as the block should hold it
	logic [BASE_W-1:0] m_base = '0;
	logic [CAP_W-1:0] m_cap = CAP_W'(65536);
	logic [TOP_W-1:0] m_top = '0;
	int m_count = 0;
	logic [OFF_W-1:0] m_rec_off [MAX_RECORDS];
	logic [PAD_W-1:0] m_rec_pad [MAX_RECORDS];

	reply_t awaited [$];
	step_row_t plan [22];
	int faults = 0;
	int idle_pct = 6;
	bit hold_output = 1'b0;

	stack_arena_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.request_size(request_size),
		.alignment(alignment),
		.data_offset(data_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_offset(result_offset),
		.padding_used(padding_used),
		.used_bytes(used_bytes),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("stack_arena_allocator_core_tb: FAIL");
		$finish;
	end

	function automatic reply_t arena_apply(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
			logic [ALIGN_W-1:0] align, logic [OFF_W-1:0] ptr);
		reply_t r;
		longint unsigned a, addr, rem, pad, total, lim, data;
		int hit, i;
		r = '0;
		r.code = ST_OK;
		case (cmd)
			CMD_ALLOC: begin
				a = (align == '0) ? DEFAULT_ALIGN : align;
				if (a > ALIGN_LIMIT)
					a = ALIGN_LIMIT;
				lim = (m_cap > (1 << ARENA_BITS)) ? (1 << ARENA_BITS) : m_cap;
				if (size == '0) begin
					r.code = ST_ZERO;
				end else begin
					addr = 64'(m_base) + 64'(m_top) + HEADER_BYTES;
					rem = addr % a;
					pad = (rem == 0) ? 0 : a - rem;
					total = pad + HEADER_BYTES + 64'(size);
					if (64'(m_top) + total > lim) begin
						r.code = ST_NOSPACE;
					end else if (m_count >= MAX_RECORDS) begin
						r.code = ST_FULL;
					end else begin
						data = 64'(m_top) + pad + HEADER_BYTES;
						m_rec_off[m_count] = OFF_W'(data);
						m_rec_pad[m_count] = PAD_W'(pad);
						m_count++;
						m_top = TOP_W'(64'(m_top) + total);
						r.offset = OFF_W'(data);
						r.pad = PAD_W'(pad);
					end
				end
			end
			CMD_FREE: begin
				if (ptr == '0) begin
					r.code = ST_NULL;
				end else begin
					hit = -1;
					for (i = 0; i < m_count && hit < 0; i++)
						if (m_rec_off[i] == ptr)
							hit = i;
					if (hit < 0) begin
						r.code = ST_UNKNOWN;
					end else begin
						m_top = TOP_W'(ptr - m_rec_pad[hit] - HEADER_BYTES);
						m_count = hit;
					end
				end
			end
			CMD_RESET: begin
				m_top = '0;
				m_count = 0;
			end
			default: begin
			end
		endcase
		r.used = m_top;
		return r;
	endfunction

	task automatic offer(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
			logic [ALIGN_W-1:0] align, logic [OFF_W-1:0] ptr, bit typed, reply_t want);
		reply_t got;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		request_size <= size;
		alignment <= align;
		data_offset <= ptr;
		do @(posedge clk); while (!in_ready);
		got = arena_apply(cmd, size, align, ptr);
		awaited.push_back(typed ? want : got);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_arena_config(logic [BASE_W-1:0] base, logic [CAP_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data <= base;
		do @(posedge clk); while (!cfg_ready);
		m_base = base;
		cfg_index <= REG_CAP;
		cfg_data <= BASE_W'(cap);
		do @(posedge clk); while (!cfg_ready);
		m_cap = cap;
		cfg_valid <= 1'b0;
	endtask

	// mostly LIFO-shaped traffic: allocs, frees of live blocks, some noise
	task automatic random_beat(int alloc_pct, bit fill);
		logic [CMD_W-1:0] c;
		logic [SIZE_W-1:0] s;
		logic [ALIGN_W-1:0] al;
		logic [OFF_W-1:0] p;
		int k;
		c = CMD_ALLOC;
		s = SIZE_W'($urandom);
		al = ALIGN_W'($urandom);
		p = OFF_W'($urandom);
		if ($urandom_range(99) < alloc_pct) begin
			k = $urandom_range(99);
			if (fill || k < 70)
				s = SIZE_W'($urandom_range(1, 48));
			else if (k < 85)
				s = SIZE_W'($urandom_range(1, 4096));
			else if (k < 90)
				s = '0;
			else if (k >= 95)
				s = SIZE_W'($urandom_range(60000, 65536));
			k = $urandom_range(99);
			if (k < 30)
				al = '0;
			else if (k < 60)
				al = ALIGN_W'(1 << $urandom_range(0, 12));
			else if (k < 85)
				al = ALIGN_W'($urandom_range(1, 64));
		end else begin
			k = $urandom_range(99);
			if (k < 85) begin
				c = CMD_FREE;
				k = $urandom_range(99);
				if (m_count > 0 && k < 50)
					p = m_rec_off[m_count - 1];
				else if (m_count > 0 && k < 75)
					p = m_rec_off[$urandom_range(0, m_count - 1)];
				else if (k < 85)
					p = '0;
				else if (m_count > 0 && k < 92)
					p = m_rec_off[$urandom_range(0, m_count - 1)] + 1'b1;
			end else if (k < 93) begin
				c = CMD_RESET;
			end else begin
				c = CMD_UNDEF;
			end
		end
		offer(c, s, al, p, 1'b0, NONE);
	endtask

	task automatic run_phase(logic [BASE_W-1:0] base, logic [CAP_W-1:0] cap, int beats,
			int alloc_pct, bit fill);
		settle();
		set_arena_config(base, cap);
		repeat (beats)
			random_beat(alloc_pct, fill);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic compare_field(string name, int want, int got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$display("%0t: result beat with nothing pending, status %0d used %0d",
					$time, status, used_bytes);
				faults++;
			end else begin
				reply_t e;
				e = awaited.pop_front();
				compare_field("status", e.code, status);
				compare_field("result_offset", e.offset, result_offset);
				compare_field("padding_used", e.pad, padding_used);
				compare_field("used_bytes", e.used, used_bytes);
			end
		end
	end

	initial begin
		plan = '{
			'{CMD_ALLOC, 17'd0,      13'd0,    16'd0,      1'b1, '{ST_ZERO, 16'd0, 12'd0, 17'd0}},
			'{CMD_ALLOC, 17'd1,      13'd0,    16'hFFFF,   1'b1, '{ST_OK, 16'd16, 12'd0, 17'd17}},
			'{CMD_ALLOC, 17'd1,      13'd1,    16'd0,      1'b1, '{ST_OK, 16'd33, 12'd0, 17'd34}},
			'{CMD_ALLOC, 17'd100,    13'd4096, 16'd0,      1'b1,
				'{ST_OK, 16'd4096, 12'd4046, 17'd4196}},
			'{CMD_ALLOC, 17'd7,      13'h1FFF, 16'd0,      1'b0, NONE},
			'{CMD_ALLOC, 17'd5,      13'd3,    16'd0,      1'b0, NONE},
			'{CMD_FREE,  17'h1FFFF,  13'h1FFF, 16'd0,      1'b1, '{ST_NULL, 16'd0, 12'd0, 17'd8222}},
			'{CMD_FREE,  17'd0,      13'd0,    16'hFFFF,   1'b1,
				'{ST_UNKNOWN, 16'd0, 12'd0, 17'd8222}},
			'{CMD_FREE,  17'd0,      13'd0,    16'd17,     1'b1,
				'{ST_UNKNOWN, 16'd0, 12'd0, 17'd8222}},
			'{CMD_FREE,  17'd0,      13'd0,    16'd8192,   1'b0, NONE},
			'{CMD_FREE,  17'd0,      13'd0,    16'd8217,   1'b1,
				'{ST_UNKNOWN, 16'd0, 12'd0, 17'd4196}},
			'{CMD_ALLOC, 17'd65536,  13'd0,    16'd0,      1'b1,
				'{ST_NOSPACE, 16'd0, 12'd0, 17'd4196}},
			'{CMD_ALLOC, 17'h1FFFF,  13'h1FFF, 16'hFFFF,   1'b1,
				'{ST_NOSPACE, 16'd0, 12'd0, 17'd4196}},
			'{CMD_UNDEF, 17'h1FFFF,  13'h1FFF, 16'hFFFF,   1'b1, '{ST_OK, 16'd0, 12'd0, 17'd4196}},
			'{CMD_FREE,  17'd0,      13'd0,    16'd16,     1'b1, '{ST_OK, 16'd0, 12'd0, 17'd0}},
			'{CMD_ALLOC, 17'd65520,  13'd0,    16'd0,      1'b1, '{ST_OK, 16'd16, 12'd0, 17'd65536}},
			'{CMD_ALLOC, 17'd1,      13'd0,    16'd0,      1'b1,
				'{ST_NOSPACE, 16'd0, 12'd0, 17'd65536}},
			'{CMD_FREE,  17'd0,      13'd0,    16'd16,     1'b1, '{ST_OK, 16'd0, 12'd0, 17'd0}},
			'{CMD_ALLOC, 17'd65520,  13'd32,   16'd0,      1'b1, '{ST_NOSPACE, 16'd0, 12'd0, 17'd0}},
			'{CMD_ALLOC, 17'd40,     13'd4096, 16'd0,      1'b0, NONE},
			'{CMD_RESET, 17'h1FFFF,  13'h1FFF, 16'hFFFF,   1'b1, '{ST_OK, 16'd0, 12'd0, 17'd0}},
			'{CMD_FREE,  17'd0,      13'd0,    16'd4096,   1'b1, '{ST_UNKNOWN, 16'd0, 12'd0, 17'd0}}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[i])
			offer(plan[i].cmd, plan[i].size, plan[i].align, plan[i].ptr, plan[i].typed,
				plan[i].want);

		settle();
		set_arena_config('0, CAP_W'(65536));
		hold_output = 1'b1;
		repeat (150)
			random_beat(55, 1'b0);

		// back-to-back stretch, no idling on either side, drives the table full
		idle_pct = 0;
		run_phase('1, '1, 160, 95, 1'b1);
		idle_pct = 6;

		run_phase($urandom, '0, 40, 50, 1'b0);
		run_phase($urandom, CAP_W'($urandom_range(200, 6000)), 140, 60, 1'b0);
		run_phase($urandom, CAP_W'(65536), 160, 60, 1'b0);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("stack_arena_allocator_core_tb: PASS");
		else
			$display("stack_arena_allocator_core_tb: FAIL");
		$finish;
	end

endmodule
